// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the solver controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCAS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("mcas assertion failed");
`define MCAS_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("mcas forbidden condition");
`else
`define MCAS_ASSERT(lbl, clk, rstn, prop)
`define MCAS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/core/mcas_pkg.sv -----
// Shared constants, codes and controller/datapath command types of the solver.
package mcas_pkg;

    localparam int MAX_N_DEF     = 16;
    localparam int COST_BITS_DEF = 16;

    localparam int SIZE_W     = 5;
    localparam int ROUNDS_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int COST_W     = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_DATA_W = 2 * OUT_IDX_W;

    localparam logic [SIZE_W-1:0]   SIZE_RST   = SIZE_W'(16);
    localparam logic [ROUNDS_W-1:0] ROUNDS_RST = ROUNDS_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_SIZE = 1'b0,
        CFG_MAX_ROUNDS  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        WR_LOAD = 2'd0,
        WR_SUB  = 2'd1,
        WR_ADJ  = 2'd2
    } t_wr_op;

    typedef struct packed {
        logic   mem_rd;
        logic   mem_wr;
        t_wr_op wr_op;
        logic   load_sel;
        logic   row_stk;
        logic   min_init;
        logic   min_upd;
        logic   min_mask;
        logic   clr_match;
        logic   set_diag;
        logic   set_match;
        logic   clr_marks;
        logic   push_start;
        logic   push_col;
        logic   push_row;
        logic   flip;
        logic   out_load;
        logic   out_fail;
        logic   out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic rdata_zero;
        logic row_matched;
        logic col_free;
        logic col_marked;
    } t_dp_stat;

endpackage

// ----- rtl/core/mcas_dp.sv -----
// Solver datapath: cost store, minimum unit, matching, marks, path stack, result register.
module mcas_dp #(
    parameter int MAX_N     = mcas_pkg::MAX_N_DEF,
    parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
    input  logic                                   i_clk,
    input  mcas_pkg::t_dp_cmd                      i_cmd,
    input  logic [$clog2(MAX_N+1)-1:0]             i_n,
    input  logic [$clog2(MAX_N)-1:0]               i_row,
    input  logic [$clog2(MAX_N)-1:0]               i_col,
    input  logic [$clog2(MAX_N)-1:0]               i_sidx,
    input  logic [$clog2(MAX_N*MAX_N)-1:0]         i_load_addr,
    input  logic [mcas_pkg::COST_W-1:0]            i_cost,
    output mcas_pkg::t_dp_stat                     o_stat,
    output logic [$clog2(MAX_N)-1:0]               o_stk_col,
    output logic [mcas_pkg::OUT_DATA_W-1:0]        o_data,
    output logic                                   o_fail,
    output logic                                   o_last
);
    import mcas_pkg::*;

    localparam int IW    = $clog2(MAX_N);
    localparam int NW    = $clog2(MAX_N + 1);
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = COST_BITS + 8;
    localparam int PW    = IW + NW;
    localparam logic [COST_W-1:0] CMASK =
        (COST_BITS >= COST_W) ? '1 : COST_W'((32'd1 << COST_BITS) - 32'd1);
    localparam logic [NW-1:0] UNMATCHED = NW'(MAX_N);

    logic [SW-1:0] r_mem [DEPTH];
    logic [SW-1:0] r_rdata;
    logic [SW-1:0] r_min;
    logic          r_any;
    logic [NW-1:0] r_row_match [MAX_N];
    logic [NW-1:0] r_col_owner [MAX_N];
    logic [MAX_N-1:0] r_row_mark;
    logic [MAX_N-1:0] r_col_mark;
    logic [IW-1:0] r_stk_row [MAX_N];
    logic [IW-1:0] r_stk_col [MAX_N];
    logic [OUT_IDX_W-1:0] r_out_row;
    logic [OUT_IDX_W-1:0] r_out_col;
    logic          r_out_fail;
    logic          r_out_last;

    logic [IW-1:0] w_mrow;
    logic [PW-1:0] w_prod;
    logic [AW-1:0] w_addr;
    logic [SW-1:0] w_eff_min;
    logic [SW:0]   w_sum;
    logic [SW-1:0] w_sat;
    logic [SW-1:0] w_wdata;
    logic          w_rm;
    logic          w_cm;
    logic          w_take;
    logic [IW-1:0] w_owner;
    logic [IW-1:0] w_fl_row;
    logic [IW-1:0] w_fl_col;

    assign w_mrow  = i_cmd.row_stk ? r_stk_row[i_sidx] : i_row;
    assign w_prod  = PW'(w_mrow) * PW'(i_n) + PW'(i_col);
    assign w_addr  = i_cmd.load_sel ? i_load_addr : AW'(w_prod);
    assign w_rm    = r_row_mark[i_row];
    assign w_cm    = r_col_mark[i_col];
    assign w_eff_min = r_any ? r_min : '0;
    assign w_sum   = {1'b0, r_rdata} + {1'b0, w_eff_min};
    assign w_sat   = w_sum[SW] ? '1 : w_sum[SW-1:0];
    assign w_owner = r_col_owner[i_col][IW-1:0];
    assign w_fl_row = r_stk_row[i_sidx];
    assign w_fl_col = r_stk_col[i_sidx];
    // Reduction takes its first entry as the seed; adjustment only strictly smaller.
    assign w_take  = (!i_cmd.min_mask || (w_rm && !w_cm)) &&
                     ((r_rdata < r_min) || (!i_cmd.min_mask && !r_any));

    always_comb begin
        case (i_cmd.wr_op)
            WR_LOAD: w_wdata = SW'(i_cost & CMASK);
            WR_SUB:  w_wdata = r_rdata - w_eff_min;
            WR_ADJ: begin
                if (w_rm && !w_cm) begin
                    w_wdata = r_rdata - w_eff_min;
                end else if (!w_rm && w_cm) begin
                    w_wdata = w_sat;
                end else begin
                    w_wdata = r_rdata;
                end
            end
            default: w_wdata = r_rdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.min_init) begin
            r_min <= '1;
            r_any <= 1'b0;
        end else if (i_cmd.min_upd && w_take) begin
            r_min <= r_rdata;
            r_any <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_match) begin
            for (int k = 0; k < MAX_N; k++) begin
                r_row_match[k] <= UNMATCHED;
                r_col_owner[k] <= UNMATCHED;
            end
        end else if (i_cmd.set_diag) begin
            for (int k = 0; k < MAX_N; k++) begin
                if (k < int'(i_n)) begin
                    r_row_match[k] <= NW'(k);
                    r_col_owner[k] <= NW'(k);
                end
            end
        end else if (i_cmd.set_match) begin
            r_row_match[i_row] <= NW'(i_col);
            r_col_owner[i_col] <= NW'(i_row);
        end else if (i_cmd.flip) begin
            r_row_match[w_fl_row] <= NW'(w_fl_col);
            r_col_owner[w_fl_col] <= NW'(w_fl_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_marks) begin
            r_row_mark <= '0;
            r_col_mark <= '0;
        end else begin
            if (i_cmd.push_start) begin
                r_row_mark[i_row] <= 1'b1;
                r_stk_row[i_sidx] <= i_row;
            end
            if (i_cmd.push_col) begin
                r_col_mark[i_col] <= 1'b1;
                r_stk_col[i_sidx] <= i_col;
            end
            if (i_cmd.push_row) begin
                r_row_mark[w_owner] <= 1'b1;
                r_stk_row[i_sidx]   <= w_owner;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= i_cmd.out_fail ? '0 : OUT_IDX_W'(i_row);
            r_out_col  <= i_cmd.out_fail ? '0 : OUT_IDX_W'(r_row_match[i_row]);
            r_out_fail <= i_cmd.out_fail;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_stat.rdata_zero  = (r_rdata == '0);
    assign o_stat.row_matched = (r_row_match[i_row] < i_n);
    assign o_stat.col_free    = (r_col_owner[i_col] >= i_n);
    assign o_stat.col_marked  = r_col_mark[i_col];
    assign o_stk_col = r_stk_col[i_sidx];
    assign o_data    = {r_out_col, r_out_row};
    assign o_fail    = r_out_fail;
    assign o_last    = r_out_last;

endmodule

// ----- rtl/core/mcas_ctrl.sv -----
// Solver controller: configuration, load counting and the Hungarian method sequence.
module mcas_ctrl #(
    parameter int MAX_N = mcas_pkg::MAX_N_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcas_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcas_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  mcas_pkg::t_dp_stat                  i_stat,
    input  logic [$clog2(MAX_N)-1:0]            i_stk_col,
    output mcas_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_N+1)-1:0]          o_n,
    output logic [$clog2(MAX_N)-1:0]            o_row,
    output logic [$clog2(MAX_N)-1:0]            o_col,
    output logic [$clog2(MAX_N)-1:0]            o_sidx,
    output logic [$clog2(MAX_N*MAX_N)-1:0]      o_load_addr
);
    import mcas_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int AW = $clog2(MAX_N * MAX_N);
    localparam int LW = $clog2(MAX_N * MAX_N + 1);

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_RCHK     = 23'h000002,
        S_RED_RD   = 23'h000004,
        S_RED_MIN  = 23'h000008,
        S_RED_SRD  = 23'h000010,
        S_RED_SUB  = 23'h000020,
        S_DIAG_RD  = 23'h000040,
        S_DIAG_CHK = 23'h000080,
        S_GRD_RD   = 23'h000100,
        S_GRD_CHK  = 23'h000200,
        S_PASS     = 23'h000400,
        S_ROW      = 23'h000800,
        S_SCAN     = 23'h001000,
        S_TEST     = 23'h002000,
        S_PUSH     = 23'h004000,
        S_BACK     = 23'h008000,
        S_FLIP     = 23'h010000,
        S_ADJ_RD   = 23'h020000,
        S_ADJ_MIN  = 23'h040000,
        S_ADJ_WRD  = 23'h080000,
        S_ADJ_WR   = 23'h100000,
        S_EMIT     = 23'h200000,
        S_FAIL     = 23'h400000
    } t_state;

    t_state                r_state, n_state;
    logic [SIZE_W-1:0]     r_size;
    logic [ROUNDS_W-1:0]   r_max_rounds;
    logic [NW-1:0]         r_i, n_i;
    logic [NW-1:0]         r_j, n_j;
    logic [NW-1:0]         r_d, n_d;
    logic [NW-1:0]         r_assigned, n_assigned;
    logic [ROUNDS_W-1:0]   r_round, n_round;
    logic [LW-1:0]         r_load_cnt, n_load_cnt;
    logic                  r_col_phase, n_col_phase;
    logic                  r_progress, n_progress;
    logic                  r_out_valid;

    logic [NW-1:0] w_n;
    logic [LW-1:0] w_nn;
    logic          w_i_last;
    logic          w_j_last;
    logic          w_out_free;
    logic          w_take;
    logic [NW-1:0] w_asg_nx;

    // Clamp the size register into 1..MAX_N.
    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (int'(r_size) > MAX_N) begin
            w_n = NW'(MAX_N);
        end else begin
            w_n = NW'(r_size);
        end
    end

    assign w_nn       = LW'(w_n) * LW'(w_n);
    assign w_i_last   = (r_i == w_n - NW'(1));
    assign w_j_last   = (r_j == w_n - NW'(1));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_take     = i_stat.rdata_zero && i_stat.col_free;
    assign w_asg_nx   = r_assigned + NW'(w_take);
    assign o_n        = w_n;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_load_addr = r_load_cnt[AW-1:0];

    always_comb begin
        o_row  = r_i[IW-1:0];
        o_col  = r_j[IW-1:0];
        o_sidx = r_d[IW-1:0];
        if (r_col_phase && (r_state == S_RED_RD || r_state == S_RED_MIN ||
                            r_state == S_RED_SRD || r_state == S_RED_SUB)) begin
            o_row = r_j[IW-1:0];
            o_col = r_i[IW-1:0];
        end
        if (r_state == S_DIAG_RD || r_state == S_DIAG_CHK) begin
            o_col = r_i[IW-1:0];
        end
        if (r_state == S_ROW) begin
            o_sidx = '0;
        end
        if (r_state == S_FLIP) begin
            o_sidx = r_j[IW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_d         = r_d;
        n_round     = r_round;
        n_load_cnt  = r_load_cnt;
        n_col_phase = r_col_phase;
        n_progress  = r_progress;
        n_assigned  = r_assigned;
        o_cmd       = '0;
        o_cmd.wr_op = WR_SUB;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (r_load_cnt < w_nn) begin
                        o_cmd.mem_wr   = 1'b1;
                        o_cmd.wr_op    = WR_LOAD;
                        o_cmd.load_sel = 1'b1;
                        n_load_cnt     = r_load_cnt + LW'(1);
                    end
                    if (i_s_tlast) begin
                        n_load_cnt = '0;
                        n_round    = '0;
                        n_state    = S_RCHK;
                    end
                end
            end
            S_RCHK: begin
                if (r_round >= r_max_rounds) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.clr_match = 1'b1;
                    o_cmd.min_init  = 1'b1;
                    n_i = '0;
                    n_j = '0;
                    n_col_phase = 1'b0;
                    n_state = S_RED_RD;
                end
            end
            S_RED_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_RED_MIN;
            end
            S_RED_MIN: begin
                o_cmd.min_upd = 1'b1;
                if (w_j_last) begin
                    n_j = '0;
                    n_state = S_RED_SRD;
                end else begin
                    n_j = r_j + NW'(1);
                    n_state = S_RED_RD;
                end
            end
            S_RED_SRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_RED_SUB;
            end
            S_RED_SUB: begin
                o_cmd.mem_wr = 1'b1;
                if (w_j_last) begin
                    n_j = '0;
                    o_cmd.min_init = 1'b1;
                    if (w_i_last) begin
                        n_i = '0;
                        if (r_col_phase) begin
                            n_state = S_DIAG_RD;
                        end else begin
                            n_col_phase = 1'b1;
                            n_state = S_RED_RD;
                        end
                    end else begin
                        n_i = r_i + NW'(1);
                        n_state = S_RED_RD;
                    end
                end else begin
                    n_j = r_j + NW'(1);
                    n_state = S_RED_SRD;
                end
            end
            S_DIAG_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_DIAG_CHK;
            end
            S_DIAG_CHK: begin
                if (!i_stat.rdata_zero) begin
                    n_i = '0;
                    n_j = '0;
                    n_assigned = '0;
                    n_state = S_GRD_RD;
                end else if (w_i_last) begin
                    o_cmd.set_diag = 1'b1;
                    n_i = '0;
                    n_state = S_EMIT;
                end else begin
                    n_i = r_i + NW'(1);
                    n_state = S_DIAG_RD;
                end
            end
            S_GRD_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_GRD_CHK;
            end
            S_GRD_CHK: begin
                o_cmd.set_match = w_take;
                n_assigned = w_asg_nx;
                if (w_take || w_j_last) begin
                    if (w_i_last) begin
                        n_i = '0;
                        n_state = (w_asg_nx == w_n) ? S_EMIT : S_PASS;
                    end else begin
                        n_i = r_i + NW'(1);
                        n_j = '0;
                        n_state = S_GRD_RD;
                    end
                end else begin
                    n_j = r_j + NW'(1);
                    n_state = S_GRD_RD;
                end
            end
            S_PASS: begin
                o_cmd.clr_marks = 1'b1;
                n_progress = 1'b0;
                n_i = '0;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (r_i == w_n) begin
                    if (r_progress) begin
                        n_state = S_PASS;
                    end else begin
                        o_cmd.min_init = 1'b1;
                        n_i = '0;
                        n_j = '0;
                        n_state = S_ADJ_RD;
                    end
                end else if (i_stat.row_matched) begin
                    n_i = r_i + NW'(1);
                end else begin
                    o_cmd.push_start = 1'b1;
                    n_d = '0;
                    n_j = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_j == w_n) begin
                    if (r_d == '0) begin
                        n_i = r_i + NW'(1);
                        n_state = S_ROW;
                    end else begin
                        n_d = r_d - NW'(1);
                        n_state = S_BACK;
                    end
                end else if (i_stat.col_marked) begin
                    n_j = r_j + NW'(1);
                end else begin
                    o_cmd.mem_rd  = 1'b1;
                    o_cmd.row_stk = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_BACK: begin
                n_j = NW'(i_stk_col) + NW'(1);
                n_state = S_SCAN;
            end
            S_TEST: begin
                if (i_stat.rdata_zero) begin
                    o_cmd.push_col = 1'b1;
                    if (i_stat.col_free) begin
                        n_j = '0;
                        n_state = S_FLIP;
                    end else if (int'(r_d) + 1 >= MAX_N) begin
                        n_i = r_i + NW'(1);
                        n_state = S_ROW;
                    end else begin
                        n_d = r_d + NW'(1);
                        n_state = S_PUSH;
                    end
                end else begin
                    n_j = r_j + NW'(1);
                    n_state = S_SCAN;
                end
            end
            S_PUSH: begin
                o_cmd.push_row = 1'b1;
                n_j = '0;
                n_state = S_SCAN;
            end
            S_FLIP: begin
                o_cmd.flip = 1'b1;
                if (r_j == r_d) begin
                    n_progress = 1'b1;
                    n_assigned = r_assigned + NW'(1);
                    if (r_assigned + NW'(1) == w_n) begin
                        n_i = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_i = r_i + NW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_ADJ_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_ADJ_MIN;
            end
            S_ADJ_MIN: begin
                o_cmd.min_upd  = 1'b1;
                o_cmd.min_mask = 1'b1;
                n_state = S_ADJ_RD;
                if (w_j_last) begin
                    n_j = '0;
                    if (w_i_last) begin
                        n_i = '0;
                        n_state = S_ADJ_WRD;
                    end else begin
                        n_i = r_i + NW'(1);
                    end
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_ADJ_WRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_ADJ_WR;
            end
            S_ADJ_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.wr_op  = WR_ADJ;
                n_state = S_ADJ_WRD;
                if (w_j_last) begin
                    n_j = '0;
                    if (w_i_last) begin
                        n_i = '0;
                        n_round = r_round + ROUNDS_W'(1);
                        n_state = S_RCHK;
                    end else begin
                        n_i = r_i + NW'(1);
                    end
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = w_i_last;
                    if (w_i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + NW'(1);
                    end
                end
            end
            S_FAIL: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_fail = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_size       <= SIZE_RST;
            r_max_rounds <= ROUNDS_RST;
            r_i          <= '0;
            r_j          <= '0;
            r_d          <= '0;
            r_assigned   <= '0;
            r_round      <= '0;
            r_load_cnt   <= '0;
            r_col_phase  <= 1'b0;
            r_progress   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_d         <= n_d;
            r_assigned  <= n_assigned;
            r_round     <= n_round;
            r_load_cnt  <= n_load_cnt;
            r_col_phase <= n_col_phase;
            r_progress  <= n_progress;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATRIX_SIZE: r_size       <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_MAX_ROUNDS:  r_max_rounds <= i_cfg_wdata[ROUNDS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `MCAS_ASSERT(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load |-> (!r_out_valid || i_m_tready))
    `MCAS_ASSERT(a_flip_bound, i_clk, i_rst_n, (r_state == S_FLIP) |-> (r_j <= r_d))
    `MCAS_NEVER(a_depth_bound, i_clk, i_rst_n, int'(r_d) >= MAX_N)
    `MCAS_ASSERT(a_load_rearm, i_clk, i_rst_n, ($past(r_state == S_IDLE) && (r_state == S_RCHK)) |-> (r_load_cnt == '0))

endmodule

// ----- rtl/core/min_cost_assignment_solver_core.sv -----
// Top level of the minimum-cost assignment solver (Hungarian method).
//
// Usage:
//   Configure matrix_size (index 0) and max_rounds (index 1) on the write port
//   while the block is idle. Stream the n*n costs in row-major order on the
//   slave channel, one per request; tlast on the final entry starts the solve.
//   Entries are taken while the block is idle; entries beyond n*n are dropped.
//   The master channel then returns one request per row (row, column) with
//   tlast on row n-1, or a single request with tuser set when no perfect
//   match was found within max_rounds adjustment rounds.
//   Solve steps: each round runs row and column reduction, a diagonal check,
//   then greedy matching and augmenting-path passes, and an adjustment when
//   rows stay unmatched; the single-port cost store (one access per cycle,
//   registered read) bounds every step.
//   A finished result waits in the output register when the receiver stalls,
//   and the solver holds until it is taken; the slave side is ready again as
//   soon as the last result is in that register.
//   Reset (synchronous, active low) restores matrix_size 16, max_rounds 100
//   and an empty load; the cost store itself is not cleared.
module min_cost_assignment_solver_core #(
    parameter int MAX_N     = mcas_pkg::MAX_N_DEF,
    parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mcas_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mcas_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // slave side: cost matrix entries
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mcas_pkg::COST_W-1:0]        i_s_tdata,   // [15:0] cost
    input  logic                               i_s_tlast,   // last_entry
    // master side: assignment results
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mcas_pkg::OUT_DATA_W-1:0]    o_m_tdata,   // [3:0] row_index, [7:4] assigned_column
    output logic                               o_m_tuser,   // failed
    output logic                               o_m_tlast    // last_result
);
    import mcas_pkg::*;

    localparam int IW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N + 1);
    localparam int AW = $clog2(MAX_N * MAX_N);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [NW-1:0] w_n;
    logic [IW-1:0] w_row;
    logic [IW-1:0] w_col;
    logic [IW-1:0] w_sidx;
    logic [IW-1:0] w_stk_col;
    logic [AW-1:0] w_load_addr;

    // Sequencer: owns config, counters, handshakes and the algorithm steps.
    mcas_ctrl #(
        .MAX_N(MAX_N)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .i_stk_col  (w_stk_col),
        .o_cmd      (w_cmd),
        .o_n        (w_n),
        .o_row      (w_row),
        .o_col      (w_col),
        .o_sidx     (w_sidx),
        .o_load_addr(w_load_addr)
    );

    // Storage and arithmetic: cost store, minimum, matching, marks, path stack.
    mcas_dp #(
        .MAX_N    (MAX_N),
        .COST_BITS(COST_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_n        (w_n),
        .i_row      (w_row),
        .i_col      (w_col),
        .i_sidx     (w_sidx),
        .i_load_addr(w_load_addr),
        .i_cost     (i_s_tdata),
        .o_stat     (w_stat),
        .o_stk_col  (w_stk_col),
        .o_data     (o_m_tdata),
        .o_fail     (o_m_tuser),
        .o_last     (o_m_tlast)
    );

endmodule
